/* sv/tcd_pkg.sv */
// ----------------------------------------------------------------------------
// tcd_pkg
// Shared types, constants and helpers for the timed command dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package tcd_pkg;

    localparam int unsigned RECORD_LEN = 6;  // full data record, in bytes
    localparam int unsigned SHORT_LEN  = 3;  // record without data bytes
    localparam int unsigned IDX_W      = $clog2(RECORD_LEN);
    localparam int unsigned TIME_W     = 16;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [TIME_W-1:0] COUNT_MAX  = 16'hFFFF;
    localparam logic [7:0]        MASK_RESET = 8'h80;

    // Request codes carried by a transaction.
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TIMING_EN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FLAG_MASK = 1'b1;

    typedef logic [7:0] t_byte;

    // Result buffer status seen by the top level.
    typedef struct packed {
        logic full;
        logic avail;
    } t_buf_status;

    // Flag bits 1:0 on top, three data bytes below, six zero bits at the bottom.
    function automatic logic [WORD_W-1:0] pack_word(
        input t_byte flag,
        input t_byte d0,
        input t_byte d1,
        input t_byte d2
    );
        pack_word = {flag[1:0], d0, d1, d2, 6'b000000};
    endfunction

endpackage

`default_nettype wire

/* sv/tcd_out_buf.sv */
// ----------------------------------------------------------------------------
// tcd_out_buf
// Two-entry result queue; keeps the input side moving while the sink stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tcd_out_buf
    import tcd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [WORD_W-1:0] i_word,
    input  wire logic              i_pop,
    output t_buf_status            o_status,
    output logic [WORD_W-1:0]      o_word
);

    logic [WORD_W-1:0] r_word [2];
    logic              r_wr_ptr, n_wr_ptr;
    logic              r_rd_ptr, n_rd_ptr;
    logic [1:0]        r_count,  n_count;
    logic              pop_ok;

    assign pop_ok = i_pop && (r_count != 2'd0);

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ pop_ok;
        n_count  = r_count + {1'b0, i_push} - {1'b0, pop_ok};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_word[r_wr_ptr] <= i_word;
        end
    end

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.avail = (r_count != 2'd0);
    assign o_word         = r_word[r_rd_ptr];

endmodule

`default_nettype wire

/* sv/timed_command_dispatcher.sv */
// ----------------------------------------------------------------------------
// timed_command_dispatcher
// Assembles command bytes into timed records and dispatches due data records
// as packed 32-bit words against a saturating 16-bit tick counter.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------
//  input    | in        | i_valid / o_stall    | i_req_type, i_data_byte,
//           |           |                      | i_sink_ready
//  output   | out       | o_valid / i_stall    | o_output_word
//  config   | in        | i_cfg_we (no wait)   | i_cfg_idx, i_cfg_wdata
//
//  One transaction per cycle while o_stall is low: each accepted transaction is
//  fully handled in the cycle it is accepted; a resulting word appears on
//  o_valid in the following cycle, out of a two-entry result queue.
//  o_stall rises only while both queue entries wait on a stalled sink.
//  Synchronous active-low reset clears the counter, record state, the
//  configuration (timing off, mask 0x80) and the result queue.
//
`default_nettype none

module timed_command_dispatcher
    import tcd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input transactions
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_req_type,
    input  wire logic [7:0]            i_data_byte,
    input  wire logic                  i_sink_ready,
    // result transactions
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [WORD_W-1:0]          o_output_word,
    // configuration writes
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // Configuration
    logic        r_timing_en;
    t_byte       r_flag_mask;

    // Record and timing state
    logic [TIME_W-1:0] r_time,   n_time;
    logic [IDX_W-1:0]  r_nbytes, n_nbytes;
    logic              r_held,   n_held;
    t_byte             r_rec [RECORD_LEN];

    // Per-transaction decode
    logic              accept;
    logic              is_tick;
    logic              take_byte;
    logic [IDX_W-1:0]  next_nbytes;
    logic              rec_done;
    logic              check;
    logic              is_due;
    logic              is_data;
    logic              emit;
    logic              clear_time;
    logic [TIME_W-1:0] base_time;
    t_byte             view [RECORD_LEN];

    t_buf_status       buf_st;

    assign accept  = i_valid && !o_stall;
    assign is_tick = (i_req_type == REQ_TICK);

    // Bytes are refused silently while a record is held.
    assign take_byte   = accept && !is_tick && !r_held;
    assign next_nbytes = r_nbytes + IDX_W'(1);

    // Length is fixed by the mask at the time the flag byte arrives.
    assign rec_done = take_byte &&
        (((next_nbytes == IDX_W'(SHORT_LEN)) && ((i_data_byte & r_flag_mask) == 8'h00)) ||
         (next_nbytes == IDX_W'(RECORD_LEN)));

    // Record as it looks with the incoming byte merged in, so a record
    // completed by this byte is checked right away.
    always_comb begin
        for (int i = 0; i < RECORD_LEN; i++) begin
            view[i] = (take_byte && (r_nbytes == IDX_W'(i))) ? i_data_byte : r_rec[i];
        end
    end

    // With timing enabled, a check happens on record completion or on a tick with a held record.
    assign check   = r_timing_en && (rec_done || (accept && is_tick && r_held));
    assign is_due  = ({view[0], view[1]} <= r_time);
    assign is_data = ((view[2] & r_flag_mask) != 8'h00);

    assign emit       = check && is_due && is_data && i_sink_ready;
    assign clear_time = check && is_due && !is_data;

    always_comb begin
        base_time = clear_time ? '0 : r_time;
        n_time    = base_time;
        if (accept && is_tick && r_timing_en && (base_time != COUNT_MAX)) begin
            n_time = base_time + TIME_W'(1);
        end

        n_held = r_held;
        if (rec_done) begin
            n_held = 1'b1;
        end
        if (emit || clear_time) begin
            n_held = 1'b0;
        end

        n_nbytes = r_nbytes;
        if (take_byte) begin
            n_nbytes = rec_done ? '0 : next_nbytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time      <= '0;
            r_nbytes    <= '0;
            r_held      <= 1'b0;
            r_timing_en <= 1'b0;
            r_flag_mask <= MASK_RESET;
        end else begin
            r_time   <= n_time;
            r_nbytes <= n_nbytes;
            r_held   <= n_held;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_TIMING_EN: r_timing_en <= i_cfg_wdata[0];
                    REG_FLAG_MASK: r_flag_mask <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Record bytes: payload only, no reset.
    always_ff @(posedge i_clk) begin
        if (take_byte) begin
            r_rec[r_nbytes] <= i_data_byte;
        end
    end

    tcd_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (emit),
        .i_word   (pack_word(view[2], view[3], view[4], view[5])),
        .i_pop    (!i_stall),
        .o_status (buf_st),
        .o_word   (o_output_word)
    );

    assign o_stall = buf_st.full;
    assign o_valid = buf_st.avail;

endmodule

`default_nettype wire

/* sv/tcd_checker.sv */
// ----------------------------------------------------------------------------
// tcd_checker
// Port-level checks for the timed command dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcd_checker
    import tcd_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_stall,
    input wire logic                  o_valid,
    input wire logic                  i_stall,
    input wire logic [WORD_W-1:0]     o_output_word
);

    // Result held while the sink stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_output_word))
        else $error("result dropped or changed while stalled");

    // Input stall only with a result pending.
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no pending result");

    // A full queue stays full until a result drains.
    a_stall_persists: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall && i_stall |=> o_stall)
        else $error("stall released without a drained result");

    // Reset empties the result queue.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("results present after reset");

endmodule

bind timed_command_dispatcher tcd_checker u_tcd_checker (.*);

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timed command dispatcher. Byte and tick
// transactions go in with random gaps and the word sink stalls at random.
// A shadow of the dispatcher works out every packed word that is owed, and
// each word that comes out is checked in order against it.
// ----------------------------------------------------------------------------
module tb_top;
    import tcd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
    localparam int SETTLE_CYCLES  = 4;     // a word shows up in the cycle after its cause
    localparam int PRESSURE_HOLD  = 300;   // long sink hold-off, in cycles
    localparam int RANDOM_ITEMS   = 776;
    localparam int RANDOM_PHASES  = 8;

    // ------------------------------------------------------------------------
    // Shadow of the dispatcher: record assembly, tick counter and the queue
    // of packed words still owed by the block.
    // ------------------------------------------------------------------------
    class dispatcher_shadow;
        bit              en_timing;
        bit [7:0]        flag_mask;
        bit [TIME_W-1:0] tick_count;
        bit [7:0]        rec_byte [RECORD_LEN];
        bit              byte_written [RECORD_LEN];
        int unsigned     got_bytes;
        bit              held;
        bit              held_short;
        bit [WORD_W-1:0] words_owed [$];

        function void clear();
            en_timing  = 1'b0;
            flag_mask  = MASK_RESET;
            tick_count = '0;
            got_bytes  = 0;
            held       = 1'b0;
            held_short = 1'b0;
            foreach (rec_byte[i]) begin
                rec_byte[i]     = '0;
                byte_written[i] = 1'b0;
            end
            words_owed.delete();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TIMING_EN: en_timing = data[0];
                REG_FLAG_MASK: flag_mask = data;
                default: ;
            endcase
        endfunction

        // A held short record that a new mask turns into a data record would
        // pack trailing bytes; those must have been written at some point.
        function bit mask_safe(bit [7:0] m);
            return !(held && held_short && (rec_byte[2] & m) != 0 &&
                     !(byte_written[3] && byte_written[4] && byte_written[5]));
        endfunction

        function void try_send(bit sink);
            bit [TIME_W-1:0] due_at;
            due_at = {rec_byte[0], rec_byte[1]};
            if (due_at > tick_count)
                return;
            if ((rec_byte[2] & flag_mask) != 0) begin
                if (sink) begin
                    words_owed.push_back({rec_byte[2][1:0], rec_byte[3], rec_byte[4],
                                          rec_byte[5], 6'b000000});
                    held = 1'b0;
                end
            end else begin
                // due record without the flag: counter restarts, nothing out
                tick_count = '0;
                held       = 1'b0;
            end
        endfunction

        // Notes one accepted input transaction; returns 0 if the block ignores it.
        function bit take_item(logic req, logic [7:0] data, logic sink);
            if (req == REQ_BYTE) begin
                if (held)
                    return 1'b0;
                rec_byte[got_bytes]     = data;
                byte_written[got_bytes] = 1'b1;
                got_bytes++;
                if ((got_bytes == SHORT_LEN && (data & flag_mask) == 0) ||
                        got_bytes == RECORD_LEN) begin
                    held       = 1'b1;
                    held_short = (got_bytes == SHORT_LEN);
                    got_bytes  = 0;
                    if (en_timing)
                        try_send(sink);
                end
                return 1'b1;
            end
            if (!en_timing)
                return 1'b0;
            if (held)
                try_send(sink);
            if (tick_count != COUNT_MAX)
                tick_count++;
            return 1'b1;
        endfunction

        // Checks one accepted output word against the oldest owed word.
        function bit match_word(logic [WORD_W-1:0] seen, output string why);
            bit [WORD_W-1:0] want;
            why = "";
            if (words_owed.size() == 0) begin
                why = $sformatf("output_word %08h with no word owed", seen);
                return 1'b0;
            end
            want = words_owed.pop_front();
            if (seen !== want) begin
                why = $sformatf("output_word got %08h, want %08h", seen, want);
                return 1'b0;
            end
            return 1'b1;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT ports, instance
    // ------------------------------------------------------------------------
    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_valid      = 1'b0;
    logic                  o_stall;
    logic                  i_req_type   = REQ_BYTE;
    logic [7:0]            i_data_byte  = '0;
    logic                  i_sink_ready = 1'b0;
    logic                  o_valid;
    logic                  i_stall      = 1'b0;
    logic [WORD_W-1:0]     o_output_word;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata  = '0;

    dispatcher_shadow shadow = new();

    int n_errors     = 0;
    int n_sent       = 0;  // input transactions accepted so far
    int tx_gap_pct   = 30;
    int rx_stall_pct = 30;
    int hold_asks    = 0;  // bumped by the stimulus, served by the sink process

    always #5 i_clk = ~i_clk;

    timed_command_dispatcher dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_data_byte   (i_data_byte),
        .i_sink_ready  (i_sink_ready),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_output_word (o_output_word),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string why);
        n_errors++;
        $display("[%0t] mismatch: %s", $time, why);
    endtask

    function automatic logic pick_ready();
        return ($urandom_range(99) < 80);
    endfunction

    // One input transaction. Valid is set or cleared once per falling edge;
    // the payload holds until the transaction is taken.
    task automatic send_item(input logic req, input logic [7:0] data, input logic sink);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= req;
        i_data_byte  <= data;
        i_sink_ready <= sink;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        void'(shadow.take_item(req, data, sink));
        n_sent++;
    endtask

    task automatic send_tick(input logic sink);
        send_item(REQ_TICK, 8'($urandom), sink);
    endtask

    // Sends one record; its length follows the mask in force when the flag
    // byte goes in. A broken record has ticks slipped in between its bytes.
    task automatic send_record(input logic [15:0] due_at, input logic [7:0] flag,
                               input logic [23:0] payload, input logic sink,
                               input bit broken);
        logic [7:0] parts [RECORD_LEN];
        int         n_parts;
        parts   = '{due_at[15:8], due_at[7:0], flag,
                    payload[23:16], payload[15:8], payload[7:0]};
        n_parts = ((flag & shadow.flag_mask) != 0) ? RECORD_LEN : SHORT_LEN;
        for (int k = 0; k < n_parts; k++) begin
            if (broken && $urandom_range(3) == 0)
                repeat ($urandom_range(1, 3)) send_tick(pick_ready());
            send_item(REQ_BYTE, parts[k], (k == n_parts - 1) ? sink : pick_ready());
        end
    endtask

    // Due times stay close to the count so that no record sits for ages.
    task automatic random_record(input bit broken);
        logic [15:0] due_at;
        logic [7:0]  flag;
        logic [7:0]  low_bit;
        if ($urandom_range(99) < 25)
            due_at = '0;
        else
            due_at = shadow.tick_count + 16'($urandom_range(0, 5));
        flag    = 8'($urandom);
        low_bit = shadow.flag_mask & (~shadow.flag_mask + 8'd1);
        if ($urandom_range(99) < 75)
            flag = flag | low_bit;
        else
            flag = flag & ~shadow.flag_mask;
        send_record(due_at, flag, 24'($urandom), pick_ready(), broken);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        shadow.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Upper data bits are don't-care for the enable; toggle them anyway.
    task automatic set_timing(input logic on);
        cfg_write(REG_TIMING_EN, {7'($urandom), on});
    endtask

    task automatic set_mask(input logic [7:0] m);
        if (shadow.mask_safe(m))
            cfg_write(REG_FLAG_MASK, m);
    endtask

    // Stop offering, wait for every owed word, then wait out SETTLE_CYCLES so
    // that transactions that owe nothing can finish.
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (shadow.words_owed.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Mostly well-formed records and ticks; noise only while a record is
    // held, where stray bytes are refused and cannot break the framing.
    task automatic run_random(input int n_items);
        int stop_at;
        stop_at = n_sent + n_items;
        while (n_sent < stop_at) begin
            if (shadow.held) begin
                if ($urandom_range(99) < 70)
                    send_tick(pick_ready());
                else
                    send_item(1'($urandom), 8'($urandom), 1'($urandom));
            end else if ($urandom_range(99) < 60) begin
                random_record($urandom_range(99) < 15);
            end else begin
                send_tick(pick_ready());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sink side: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(negedge i_clk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = PRESSURE_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    // Output words are checked as they are taken.
    always @(posedge i_clk) begin
        string why;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (!shadow.match_word(o_output_word, why))
                report_mismatch(why);
        end
    end

    // Watchdog: any transaction on any port restarts the count.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        shadow.clear();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Timing off after reset: a full record with all-ones content is held
        // but not sent; ticks do nothing and further bytes are refused.
        send_record(16'h0000, 8'hFF, 24'hFFFFFF, 1'b1, 1'b0);
        send_tick(1'b1);
        send_item(REQ_BYTE, 8'h00, 1'b1);
        wait_idle();

        // Timing on: the held record is due, first retried with the sink busy.
        set_timing(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        // all-zero word, sink busy when it completes, sent at the next tick
        send_record(16'h0000, 8'h80, 24'h000000, 1'b0, 1'b0);
        send_tick(1'b1);
        // short record without the flag: due at once, clears the counter
        send_record(16'h0000, 8'h7F, 24'h000000, 1'b1, 1'b0);
        // not due on completion, goes out on the fourth tick
        send_record(16'h0003, 8'h81, 24'h123456, 1'b1, 1'b0);
        repeat (4) send_tick(1'b1);
        wait_idle();

        // Mask changed after the flag byte: a short record becomes a data
        // record and packs the trailing bytes left from earlier records.
        set_timing(1'b0);
        send_record(16'h0000, 8'h01, 24'h000000, 1'b1, 1'b0);
        wait_idle();
        set_mask(8'h01);
        set_timing(1'b1);
        send_tick(1'b1);
        wait_idle();

        // Random phases, each under its own setting.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: set_mask(MASK_RESET);
                1: set_mask(8'hFF);
                2: set_mask(8'h00);
                4: set_mask(8'h01);
                5: set_mask(8'hFF);
                default: set_mask(8'($urandom));
            endcase
            set_timing(p != 3);
            if (p == 4) begin
                // stretch with no idling on either side
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end
            if (p == 5) begin
                // sink holds off while records due at once keep coming, so the
                // result queue fills and the input stalls
                hold_asks++;
                repeat (20)
                    send_record(16'h0000, 8'($urandom) | 8'h01, 24'($urandom), 1'b1, 1'b0);
            end
            run_random(RANDOM_ITEMS / RANDOM_PHASES);
            tx_gap_pct   = 30;
            rx_stall_pct = 30;
            wait_idle();
        end

        // Drain any held record, then a data record due at once and a
        // flagless one that clears the counter.
        set_mask(MASK_RESET);
        set_timing(1'b1);
        while (shadow.held)
            send_tick(1'b1);
        send_record(16'h0000, 8'h82, 24'hA5C33C, 1'b1, 1'b0);
        send_record(16'h0000, 8'h02, 24'h000000, 1'b1, 1'b0);
        send_tick(1'b1);
        wait_idle();

        if (n_errors == 0 && shadow.words_owed.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
